@@ src/fdcc_pkg.sv @@
// Shared types and constants of the field-driven calendar clock.
// Holds the opcode set, the counter cell control word and the month-length table.
// Used by the counter cell and the top level.
`default_nettype none

package fdcc_pkg;

  localparam int unsigned CntW    = 7;   // widest counter: two-digit year
  localparam int unsigned NumCells = 7;
  localparam int unsigned CellIdxW = 3;

  // Position of each counter in the carry chain, fastest first
  localparam logic [CellIdxW-1:0] CellField  = 3'd0;
  localparam logic [CellIdxW-1:0] CellSecond = 3'd1;
  localparam logic [CellIdxW-1:0] CellMinute = 3'd2;
  localparam logic [CellIdxW-1:0] CellHour   = 3'd3;
  localparam logic [CellIdxW-1:0] CellDay    = 3'd4;
  localparam logic [CellIdxW-1:0] CellMonth  = 3'd5;
  localparam logic [CellIdxW-1:0] CellYear   = 3'd6;

  localparam logic [CntW-1:0] SecondsPerMinute = 7'd60;
  localparam logic [CntW-1:0] MinutesPerHour   = 7'd60;
  localparam logic [CntW-1:0] HoursPerDay      = 7'd24;
  localparam logic [CntW-1:0] MonthsPerYear    = 7'd12;
  localparam logic [CntW-1:0] YearsPerCentury  = 7'd100;
  localparam logic [CntW-1:0] FebIndex         = 7'd1;
  localparam logic [CntW-1:0] LeapDayIndex     = 7'd28;
  localparam logic [CntW-1:0] LastFebDayIndex  = 7'd27;

  localparam int unsigned FpsW        = 6;
  localparam logic [FpsW-1:0] FpsReset = 6'd50;
  localparam int unsigned ApbAddrW    = 3;
  localparam int unsigned ApbDataW    = 32;

  typedef enum logic [4:0] {
    OP_TICK        = 5'd0,
    OP_SET_YEAR    = 5'd1,
    OP_SET_MONTH   = 5'd2,
    OP_SET_DAY     = 5'd3,
    OP_SET_HOUR    = 5'd4,
    OP_SET_MINUTE  = 5'd5,
    OP_SET_SECOND  = 5'd6,
    OP_INC_YEAR    = 5'd7,
    OP_INC_MONTH   = 5'd8,
    OP_INC_DAY     = 5'd9,
    OP_INC_HOUR    = 5'd10,
    OP_INC_MINUTE  = 5'd11,
    OP_INC_SECOND  = 5'd12,
    OP_STOP_TIME   = 5'd13,
    OP_STOP_DATE   = 5'd14,
    OP_START       = 5'd15,
    OP_TAKE_UPDATE = 5'd16
  } opcode_e;

  // Per-cell command besides the carry coming down the chain
  typedef struct packed {
    logic inc;    // local step, no carry out
    logic load;   // take load value
    logic clr;    // return to zero
  } cell_ctrl_t;

  localparam logic [CntW-1:0] MonthLength [16] = '{
    7'd31, 7'd28, 7'd31, 7'd30, 7'd31, 7'd30, 7'd31, 7'd31,
    7'd30, 7'd31, 7'd30, 7'd31, 7'd31, 7'd31, 7'd31, 7'd31
  };

  function automatic logic [CntW-1:0] days_in_month(input logic [3:0] month,
                                                    input logic [1:0] year_lsbs);
    logic [CntW-1:0] len;
    len = MonthLength[month];
    if (month == FebIndex[3:0] && year_lsbs == 2'd0) begin
      len = LeapDayIndex + 7'd1;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

@@ src/fdcc_in_if.sv @@
// Command channel of the calendar clock: opcode and value words.
// Does not depend on fdcc_pkg; plain valid/ready.
`default_nettype none

interface fdcc_in_if;
  logic       valid;
  logic       ready;
  logic [4:0] opcode;
  logic [7:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

@@ src/fdcc_out_if.sv @@
// Result channel of the calendar clock: the clock read after each command.
// Plain valid/ready with the calendar fields and two status bits.
`default_nettype none

interface fdcc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] year_now;
  logic [3:0] month_now;
  logic [4:0] day_now;
  logic [4:0] hour_now;
  logic [5:0] minute_now;
  logic [5:0] second_now;
  logic [5:0] field_now;
  logic       set_rejected;
  logic       update_was_pending;

  modport source (output valid, output year_now, output month_now, output day_now,
                  output hour_now, output minute_now, output second_now,
                  output field_now, output set_rejected, output update_was_pending,
                  input ready);
  modport sink   (input valid, input year_now, input month_now, input day_now,
                  input hour_now, input minute_now, input second_now,
                  input field_now, input set_rejected, input update_was_pending,
                  output ready);
endinterface

`default_nettype wire

@@ src/fdcc_cell.sv @@
// One wrap-around counter cell of the calendar carry chain.
// Depends on fdcc_pkg for the counter width and the cell control word.
`default_nettype none

module fdcc_cell (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   carry_i,
  input  wire fdcc_pkg::cell_ctrl_t   ctrl_i,
  input  wire logic [fdcc_pkg::CntW-1:0] load_val_i,
  input  wire logic [fdcc_pkg::CntW-1:0] len_i,
  output logic                        carry_o,
  output logic [fdcc_pkg::CntW-1:0]   count_o,
  output logic [fdcc_pkg::CntW-1:0]   count_next_o
);
  import fdcc_pkg::*;

  logic [CntW-1:0] count_q, count_d;
  logic [CntW:0]   sum;
  logic            wrap;
  logic [CntW-1:0] step_val;

  always_comb begin
    sum      = {1'b0, count_q} + {{CntW{1'b0}}, 1'b1};
    wrap     = (sum >= {1'b0, len_i});
    step_val = wrap ? '0 : sum[CntW-1:0];
    if (ctrl_i.load) begin
      count_d = load_val_i;
    end else if (ctrl_i.clr) begin
      count_d = '0;
    end else if (carry_i || ctrl_i.inc) begin
      count_d = step_val;
    end else begin
      count_d = count_q;
    end
  end

  // Hand the carry on only for chain advances
  assign carry_o      = carry_i & wrap;
  assign count_o      = count_q;
  assign count_next_o = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

@@ src/field_driven_calendar_clock_core.sv @@
// Top level of the field-driven calendar clock: command decode, carry chain of
// counter cells, APB register and the result word register.
// Depends on fdcc_pkg, fdcc_in_if, fdcc_out_if and fdcc_cell.
`default_nettype none

// Channel   Dir  Handshake      Word
// in_i      in   valid/ready    opcode[4:0], value[7:0]
// out_o     out  valid/ready    calendar fields, set_rejected, update_was_pending
// APB       in   psel/penable   fields_per_second at byte address 0
//
// Flow: one command word per clock while in_i.ready is high; its result word shows on
// out_o the next cycle. The seven cells settle the whole field-to-year carry combinationally.
// Reset: counters clear, time and date stopped, fields_per_second = 50.
// Stalls: in_i.ready drops only while a result word waits and out_o.ready is
// low; the result register frees in the same cycle it is taken.

module field_driven_calendar_clock_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  fdcc_in_if.sink                              in_i,
  fdcc_out_if.source                           out_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fdcc_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [fdcc_pkg::ApbDataW-1:0]   pwdata,
  output logic [fdcc_pkg::ApbDataW-1:0]        prdata,
  output logic                                 pready
);
  import fdcc_pkg::*;

  // ---------------------------------------------------------------- APB
  logic [FpsW-1:0] fps_q;
  logic            reg_sel;

  // Register index sits in address bit 2; only register 0 exists
  assign reg_sel = (paddr[ApbAddrW-1] == 1'b0);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(ApbDataW-FpsW){1'b0}}, fps_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fps_q <= FpsReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      fps_q <= pwdata[FpsW-1:0];
    end
  end

  // ---------------------------------------------------------------- handshake
  logic out_valid_q;
  logic accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------- cell row
  cell_ctrl_t      ctrl      [NumCells];
  logic [CntW-1:0] load_val  [NumCells];
  logic [CntW-1:0] len       [NumCells];
  logic            carry_in  [NumCells];
  logic            carry_out [NumCells];
  logic [CntW-1:0] count     [NumCells];
  logic [CntW-1:0] count_nxt [NumCells];

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    fdcc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .carry_i      (carry_in[g]),
      .ctrl_i       (ctrl[g]),
      .load_val_i   (load_val[g]),
      .len_i        (len[g]),
      .carry_o      (carry_out[g]),
      .count_o      (count[g]),
      .count_next_o (count_nxt[g])
    );
  end

  logic time_stopped_q, time_stopped_d;
  logic date_stopped_q, date_stopped_d;
  logic update_pending_q, update_pending_d;
  logic tick_adv;
  logic [CntW-1:0] dim;

  // Month length from the current month and year; the date does not move
  // before the day cell has used it
  assign dim = days_in_month(count[CellMonth][3:0], count[CellYear][1:0]);

  always_comb begin
    len[CellField]  = {1'b0, fps_q};
    len[CellSecond] = SecondsPerMinute;
    len[CellMinute] = MinutesPerHour;
    len[CellHour]   = HoursPerDay;
    len[CellDay]    = dim;
    len[CellMonth]  = MonthsPerYear;
    len[CellYear]   = YearsPerCentury;
  end

  // Chain: field -> second -> minute -> hour -> (date running) day -> month -> year
  always_comb begin
    carry_in[CellField]  = tick_adv;
    carry_in[CellSecond] = carry_out[CellField];
    carry_in[CellMinute] = carry_out[CellSecond];
    carry_in[CellHour]   = carry_out[CellMinute];
    carry_in[CellDay]    = carry_out[CellHour] && !date_stopped_q;
    carry_in[CellMonth]  = carry_out[CellDay];
    carry_in[CellYear]   = carry_out[CellMonth];
  end

  // ---------------------------------------------------------------- decode
  opcode_e         op;
  logic [7:0]      value;
  logic [7:0]      vm1;
  logic            rejected;
  logic            was_pending;
  logic            year_touched;
  logic [1:0]      year_lsbs_next;

  assign op    = opcode_e'(in_i.opcode);
  assign value = in_i.value;
  assign vm1   = value - 8'd1;

  always_comb begin
    for (int i = 0; i < NumCells; i++) begin
      ctrl[i]     = '0;
      load_val[i] = value[CntW-1:0];
    end
    tick_adv         = 1'b0;
    rejected         = 1'b0;
    was_pending      = 1'b0;
    year_touched     = 1'b0;
    year_lsbs_next   = value[1:0];
    time_stopped_d   = time_stopped_q;
    date_stopped_d   = date_stopped_q;
    update_pending_d = update_pending_q;

    if (accept) begin
      case (op)
        OP_TICK: begin
          tick_adv = !time_stopped_q;
        end
        OP_SET_YEAR: begin
          if (value >= {1'b0, YearsPerCentury}) begin
            rejected = 1'b1;
          end else begin
            ctrl[CellYear].load = 1'b1;
            year_touched        = 1'b1;
          end
        end
        OP_SET_MONTH: begin
          if (vm1 >= {1'b0, MonthsPerYear}) begin
            rejected = 1'b1;
          end else begin
            ctrl[CellMonth].load = 1'b1;
            load_val[CellMonth]  = vm1[CntW-1:0];
          end
        end
        OP_SET_DAY: begin
          if (vm1 >= {1'b0, dim}) begin
            rejected = 1'b1;
          end else begin
            ctrl[CellDay].load = 1'b1;
            load_val[CellDay]  = vm1[CntW-1:0];
          end
        end
        OP_SET_HOUR: begin
          if (value >= {1'b0, HoursPerDay}) rejected = 1'b1;
          else ctrl[CellHour].load = 1'b1;
        end
        OP_SET_MINUTE: begin
          if (value >= {1'b0, MinutesPerHour}) rejected = 1'b1;
          else ctrl[CellMinute].load = 1'b1;
        end
        OP_SET_SECOND: begin
          if (value >= {1'b0, SecondsPerMinute}) begin
            rejected = 1'b1;
          end else begin
            ctrl[CellSecond].load = 1'b1;
            ctrl[CellField].clr   = 1'b1;
          end
        end
        OP_INC_YEAR: begin
          ctrl[CellYear].inc = 1'b1;
          year_touched       = 1'b1;
          // 99 wraps to 0, whose low bits are zero
          year_lsbs_next     = (count[CellYear] == YearsPerCentury - 7'd1) ? 2'd0
                                 : count[CellYear][1:0] + 2'd1;
          update_pending_d   = 1'b1;
        end
        OP_INC_MONTH: begin
          ctrl[CellMonth].inc = 1'b1;
          update_pending_d    = 1'b1;
        end
        OP_INC_DAY: begin
          ctrl[CellDay].inc = 1'b1;
          update_pending_d  = 1'b1;
        end
        OP_INC_HOUR: begin
          ctrl[CellHour].inc = 1'b1;
          update_pending_d   = 1'b1;
        end
        OP_INC_MINUTE: begin
          ctrl[CellMinute].inc = 1'b1;
          update_pending_d     = 1'b1;
        end
        OP_INC_SECOND: begin
          ctrl[CellSecond].inc = 1'b1;
          update_pending_d     = 1'b1;
        end
        OP_STOP_TIME: begin
          time_stopped_d      = 1'b1;
          ctrl[CellField].clr = 1'b1;
        end
        OP_STOP_DATE: begin
          date_stopped_d = 1'b1;
        end
        OP_START: begin
          time_stopped_d = 1'b0;
          date_stopped_d = 1'b0;
        end
        OP_TAKE_UPDATE: begin
          was_pending      = update_pending_q;
          update_pending_d = 1'b0;
        end
        default: begin
        end
      endcase

      // Drop an invalid 29 February when the year leaves a leap year
      if (year_touched && year_lsbs_next != 2'd0 &&
          count[CellMonth] == FebIndex && count[CellDay] == LeapDayIndex) begin
        ctrl[CellDay].load = 1'b1;
        load_val[CellDay]  = LastFebDayIndex;
      end

      // A completed second raises the update flag
      if (carry_out[CellField]) begin
        update_pending_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_stopped_q   <= 1'b1;
      date_stopped_q   <= 1'b1;
      update_pending_q <= 1'b0;
    end else begin
      time_stopped_q   <= time_stopped_d;
      date_stopped_q   <= date_stopped_d;
      update_pending_q <= update_pending_d;
    end
  end

  // ---------------------------------------------------------------- result word
  logic [6:0] year_q;
  logic [3:0] month_q;
  logic [4:0] day_q;
  logic [4:0] hour_q;
  logic [5:0] minute_q;
  logic [5:0] second_q;
  logic [5:0] field_q;
  logic       rejected_q;
  logic       was_pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture the clock as it stands after this command
  always_ff @(posedge clk_i) begin
    if (accept) begin
      year_q        <= count_nxt[CellYear][6:0];
      month_q       <= count_nxt[CellMonth][3:0] + 4'd1;
      day_q         <= count_nxt[CellDay][4:0] + 5'd1;
      hour_q        <= count_nxt[CellHour][4:0];
      minute_q      <= count_nxt[CellMinute][5:0];
      second_q      <= count_nxt[CellSecond][5:0];
      field_q       <= count_nxt[CellField][5:0];
      rejected_q    <= rejected;
      was_pending_q <= was_pending;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.year_now           = year_q;
  assign out_o.month_now          = month_q;
  assign out_o.day_now            = day_q;
  assign out_o.hour_now           = hour_q;
  assign out_o.minute_now         = minute_q;
  assign out_o.second_now         = second_q;
  assign out_o.field_now          = field_q;
  assign out_o.set_rejected       = rejected_q;
  assign out_o.update_was_pending = was_pending_q;

endmodule

`default_nettype wire
